/* hdl/footprint_grid_collision_check_defines.svh */
// Assertion macros for the footprint grid collision check.
`ifndef FOOTPRINT_GRID_COLLISION_CHECK_DEFINES_SVH
`define FOOTPRINT_GRID_COLLISION_CHECK_DEFINES_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge out of reset.
`define FGCC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never be true out of reset.
`define FGCC_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define FGCC_ASSERT(label, prop, msg)
`define FGCC_NEVER(label, expr, msg)
`endif
`endif

/* hdl/fgcc_pkg.sv */
// Shared types, constants and widths of the footprint grid collision check.
package fgcc_pkg;

	localparam int MAP_SIDE_MAX = 256;
	localparam int PATCH_MAX    = 32;

	// Fixed field widths
	localparam int WORD_W     = 32;
	localparam int MSIDE_W    = 9;
	localparam int LEVEL_W    = 8;
	localparam int PCOUNT_W   = 6;
	localparam int CELL_IN_W  = 16;
	localparam int TRIG_W     = 16;
	localparam int ROT_FRAC   = 15;
	localparam int CELL_FRAC  = 16;
	localparam int REG_COUNT  = 8;
	localparam int REG_IDX_W  = $clog2(REG_COUNT);

	// Derived from the map and patch limits
	localparam int MAP_CELLS = MAP_SIDE_MAX * MAP_SIDE_MAX;
	localparam int ADDR_W    = $clog2(MAP_CELLS);
	localparam int CELL_W    = $clog2(MAP_SIDE_MAX);
	localparam int SIDE_W    = $clog2(MAP_SIDE_MAX + 1);
	localparam int IDX_W     = (PATCH_MAX > 1) ? $clog2(PATCH_MAX) : 1;
	localparam int CNT_W     = $clog2(PATCH_MAX + 1);
	localparam int OFF_W     = WORD_W + IDX_W + 2;
	localparam int PROD_W    = OFF_W + TRIG_W;
	localparam int POS_W     = PROD_W + 2 - ROT_FRAC;
	localparam int EXT_W     = SIDE_W + WORD_W;
	localparam int CMP_W     = ((POS_W > EXT_W) ? POS_W : EXT_W) + 1;
	localparam int HI_W      = EXT_W - CELL_FRAC;
	localparam int HIP_W     = HI_W + WORD_W;
	localparam int LOP_W     = CELL_FRAC + WORD_W;
	localparam int TX_W      = HIP_W + 1;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_CELL_SIZE     = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_INV_CELL_SIZE = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_HALF_LENGTH   = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_HALF_WIDTH    = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_MAP_SIDE      = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_FREE_LEVEL    = REG_IDX_W'(5);
	localparam logic [REG_IDX_W-1:0] REG_PATCH_LONG    = REG_IDX_W'(6);
	localparam logic [REG_IDX_W-1:0] REG_PATCH_WIDE    = REG_IDX_W'(7);

	// Request actions
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_CHECK = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} fgcc_state_t;

	// One footprint offset from the sequencer
	typedef struct packed {
		logic                    valid;
		logic                    last;
		logic signed [OFF_W-1:0] ox;
		logic signed [OFF_W-1:0] oy;
	} fgcc_sample_t;

	// One map lookup from the transform pipeline
	typedef struct packed {
		logic              valid;
		logic              last;
		logic              outside;
		logic [ADDR_W-1:0] addr;
	} fgcc_lookup_t;

endpackage

/* hdl/fgcc_ram.sv */
// Generic simple dual-port RAM with registered read.
module fgcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* hdl/fgcc_seq.sv */
// Footprint sample sequencer: walks the patch grid, one offset per cycle.
module fgcc_seq import fgcc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CNT_W-1:0]  n_long,
	input  logic [CNT_W-1:0]  n_wide,
	input  logic [WORD_W-1:0] cell_size,
	input  logic [WORD_W-1:0] half_length,
	input  logic [WORD_W-1:0] half_width,
	output fgcc_sample_t      smp
);

	logic                    active_q;
	logic [IDX_W-1:0]        i_q;
	logic [IDX_W-1:0]        j_q;
	logic signed [OFF_W-1:0] ox_q;
	logic signed [OFF_W-1:0] oy_q;
	logic signed [OFF_W-1:0] step;
	logic signed [OFF_W-1:0] hl_ext;
	logic signed [OFF_W-1:0] hw_ext;
	logic                    row_end;
	logic                    last;

	assign step    = {{(OFF_W-WORD_W){1'b0}}, cell_size};
	assign hl_ext  = {{(OFF_W-WORD_W){1'b0}}, half_length};
	assign hw_ext  = {{(OFF_W-WORD_W){1'b0}}, half_width};
	assign row_end = CNT_W'(j_q) == n_wide - CNT_W'(1);
	assign last    = row_end && (CNT_W'(i_q) == n_long - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (start) begin
			active_q <= 1'b1;
		end else if (active_q && last) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			i_q  <= '0;
			j_q  <= '0;
			ox_q <= '0 - hl_ext;
			oy_q <= '0 - hw_ext;
		end else if (active_q) begin
			if (row_end) begin
				// wrap to the next row of the patch
				j_q  <= '0;
				oy_q <= '0 - hw_ext;
				i_q  <= i_q + IDX_W'(1);
				ox_q <= ox_q + step;
			end else begin
				j_q  <= j_q + IDX_W'(1);
				oy_q <= oy_q + step;
			end
		end
	end

	assign smp.valid = active_q;
	assign smp.last  = last;
	assign smp.ox    = ox_q;
	assign smp.oy    = oy_q;

endmodule

/* hdl/fgcc_xform.sv */
// Rotate, translate, bound-check and map each footprint offset to a cell address.
module fgcc_xform import fgcc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  fgcc_sample_t             smp,
	input  logic signed [WORD_W-1:0] pos_x,
	input  logic signed [WORD_W-1:0] pos_y,
	input  logic signed [TRIG_W-1:0] cos_yaw,
	input  logic signed [TRIG_W-1:0] sin_yaw,
	input  logic [EXT_W-1:0]         extent,
	input  logic [WORD_W-1:0]        inv_cell_size,
	input  logic [SIDE_W-1:0]        side,
	output fgcc_lookup_t             lookup
);

	// Stage 1: rotation products
	logic                     valid_s1, last_s1;
	logic signed [PROD_W-1:0] oxc_s1, oys_s1, oxs_s1, oyc_s1;
	// Stage 2: world point
	logic                     valid_s2, last_s2;
	logic signed [POS_W-1:0]  px_s2, py_s2;
	// Stage 3: bounds and reciprocal products
	logic                     valid_s3, last_s3, outside_s3;
	logic [HIP_W-1:0]         hix_s3, hiy_s3;
	logic [LOP_W-1:0]         lox_s3, loy_s3;
	// Stage 4: clamped cell coordinates
	logic                     valid_s4, last_s4, outside_s4;
	logic [CELL_W-1:0]        cx_s4, cy_s4;
	// Stage 5: cell address
	logic                     valid_s5, last_s5, outside_s5;
	logic [ADDR_W-1:0]        addr_s5;

	logic signed [PROD_W:0]   dx, dy;
	logic signed [POS_W-1:0]  px, py;
	logic signed [CMP_W-1:0]  px_c, py_c, ext_c;
	logic [EXT_W-1:0]         ux, uy;
	logic                     outside;
	logic [TX_W-1:0]          tx, ty;
	logic [TX_W-CELL_FRAC-1:0] fx, fy;
	logic [TX_W-CELL_FRAC-1:0] side_m1;
	logic [CELL_W-1:0]        cx, cy;
	logic [ADDR_W-1:0]        addr;

	// floor of the Q.31 rotated offset to Q16.16, plus position
	always_comb begin
		dx = oxc_s1 - oys_s1;
		dy = oxs_s1 + oyc_s1;
		px = POS_W'(dx >>> ROT_FRAC) + POS_W'(pos_x);
		py = POS_W'(dy >>> ROT_FRAC) + POS_W'(pos_y);
	end

	always_comb begin
		px_c    = CMP_W'(px_s2);
		py_c    = CMP_W'(py_s2);
		ext_c   = $signed(CMP_W'(extent));
		outside = px_c < 0 || py_c < 0 || px_c >= ext_c || py_c >= ext_c;
		ux      = px_c[EXT_W-1:0];
		uy      = py_c[EXT_W-1:0];
	end

	// finish floor(p * inv / 2^32) and limit to the last cell
	always_comb begin
		tx      = TX_W'(hix_s3) + TX_W'(lox_s3 >> CELL_FRAC);
		ty      = TX_W'(hiy_s3) + TX_W'(loy_s3 >> CELL_FRAC);
		fx      = tx[TX_W-1:CELL_FRAC];
		fy      = ty[TX_W-1:CELL_FRAC];
		side_m1 = (TX_W-CELL_FRAC)'(side) - (TX_W-CELL_FRAC)'(1);
		cx      = (fx > side_m1) ? CELL_W'(side_m1) : CELL_W'(fx);
		cy      = (fy > side_m1) ? CELL_W'(side_m1) : CELL_W'(fy);
	end

	assign addr = ADDR_W'(cy_s4) * ADDR_W'(side) + ADDR_W'(cx_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= smp.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		last_s1    <= smp.last;
		oxc_s1     <= smp.ox * cos_yaw;
		oys_s1     <= smp.oy * sin_yaw;
		oxs_s1     <= smp.ox * sin_yaw;
		oyc_s1     <= smp.oy * cos_yaw;

		last_s2    <= last_s1;
		px_s2      <= px;
		py_s2      <= py;

		last_s3    <= last_s2;
		outside_s3 <= outside;
		hix_s3     <= HIP_W'(ux[EXT_W-1:CELL_FRAC]) * HIP_W'(inv_cell_size);
		hiy_s3     <= HIP_W'(uy[EXT_W-1:CELL_FRAC]) * HIP_W'(inv_cell_size);
		lox_s3     <= LOP_W'(ux[CELL_FRAC-1:0]) * LOP_W'(inv_cell_size);
		loy_s3     <= LOP_W'(uy[CELL_FRAC-1:0]) * LOP_W'(inv_cell_size);

		last_s4    <= last_s3;
		outside_s4 <= outside_s3;
		cx_s4      <= cx;
		cy_s4      <= cy;

		last_s5    <= last_s4;
		outside_s5 <= outside_s4;
		addr_s5    <= addr;
	end

	assign lookup.valid   = valid_s5;
	assign lookup.last    = last_s5;
	assign lookup.outside = outside_s5;
	assign lookup.addr    = addr_s5;

endmodule

/* hdl/footprint_grid_collision_check.sv */
// Footprint grid collision check: cost map store, sample walk and verdict.
// Usage:
//   Input channel (in_valid/in_stall) carries one request per accept. A write
//   request (action 0) stores cell_value at cell_index and gives no result.
//   A check request (action 1) gives one result, pose_free, on the output
//   channel (out_valid/out_stall).
//   A check makes one cost map read per footprint sample, nl*nw reads in all,
//   nl and nw being the patch counts; the samples are fed one per cycle by
//   the sample walker into a six-stage transform and lookup path. An empty
//   patch skips the walk and goes straight to the result. in_stall stays
//   high while a check is in flight.
//   The result sits in an output register; while out_stall holds it, write
//   requests are still taken, and a finished check waits for the register.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
//   Reset restores the register defaults and clears all control state; the
//   cost map holds no defined contents until written.
`include "footprint_grid_collision_check_defines.svh"
module footprint_grid_collision_check import fgcc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [REG_IDX_W-1:0]     cfg_index,
	input  logic [WORD_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     action,
	input  logic [CELL_IN_W-1:0]     cell_index,
	input  logic [LEVEL_W-1:0]       cell_value,
	input  logic signed [WORD_W-1:0] pos_x,
	input  logic signed [WORD_W-1:0] pos_y,
	input  logic signed [TRIG_W-1:0] cos_yaw,
	input  logic signed [TRIG_W-1:0] sin_yaw,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     pose_free
);

	logic [WORD_W-1:0]   cell_size_q, inv_cell_size_q, half_length_q, half_width_q;
	logic [MSIDE_W-1:0]  map_side_q;
	logic [LEVEL_W-1:0]  free_level_q;
	logic [PCOUNT_W-1:0] patch_long_q, patch_wide_q;

	logic signed [WORD_W-1:0] x_q, y_q;
	logic signed [TRIG_W-1:0] c_q, s_q;
	logic [EXT_W-1:0]         extent_q;

	fgcc_state_t state_q, state_d;
	logic        free_q;
	logic        out_valid_q, pose_free_q;
	logic        valid_s6, last_s6, outside_s6;

	logic [SIDE_W-1:0] side_c;
	logic [CNT_W-1:0]  nl_c, nw_c;
	logic              in_acc, acc_check, acc_write, empty_patch;
	logic              slot_free, start_seq, load_out, sample_ok;
	logic [LEVEL_W-1:0] rd_data;

	fgcc_sample_t smp;
	fgcc_lookup_t lookup;

	// Saturate the geometry registers; a zero map side counts as one
	always_comb begin
		if (map_side_q == '0) begin
			side_c = SIDE_W'(1);
		end else if (32'(map_side_q) > MAP_SIDE_MAX) begin
			side_c = SIDE_W'(MAP_SIDE_MAX);
		end else begin
			side_c = SIDE_W'(map_side_q);
		end
		nl_c = (32'(patch_long_q) > PATCH_MAX) ? CNT_W'(PATCH_MAX) : CNT_W'(patch_long_q);
		nw_c = (32'(patch_wide_q) > PATCH_MAX) ? CNT_W'(PATCH_MAX) : CNT_W'(patch_wide_q);
	end

	assign in_acc      = in_valid && !in_stall;
	assign acc_check   = in_acc && action == ACT_CHECK;
	assign acc_write   = in_acc && action == ACT_WRITE && 32'(cell_index) < MAP_CELLS;
	assign empty_patch = nl_c == '0 || nw_c == '0;
	assign slot_free   = !out_valid_q || !out_stall;
	assign sample_ok   = !outside_s6 && rd_data >= free_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q     <= WORD_W'(65536);
			inv_cell_size_q <= WORD_W'(65536);
			half_length_q   <= WORD_W'(131072);
			half_width_q    <= WORD_W'(65536);
			map_side_q      <= MSIDE_W'(256);
			free_level_q    <= LEVEL_W'(250);
			patch_long_q    <= PCOUNT_W'(4);
			patch_wide_q    <= PCOUNT_W'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CELL_SIZE:     cell_size_q     <= cfg_data;
				REG_INV_CELL_SIZE: inv_cell_size_q <= cfg_data;
				REG_HALF_LENGTH:   half_length_q   <= cfg_data;
				REG_HALF_WIDTH:    half_width_q    <= cfg_data;
				REG_MAP_SIDE:      map_side_q      <= cfg_data[MSIDE_W-1:0];
				REG_FREE_LEVEL:    free_level_q    <= cfg_data[LEVEL_W-1:0];
				REG_PATCH_LONG:    patch_long_q    <= cfg_data[PCOUNT_W-1:0];
				REG_PATCH_WIDE:    patch_wide_q    <= cfg_data[PCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the pose and map extent for the walk
	always_ff @(posedge clk) begin
		if (acc_check) begin
			x_q      <= pos_x;
			y_q      <= pos_y;
			c_q      <= cos_yaw;
			s_q      <= sin_yaw;
			extent_q <= EXT_W'(side_c) * EXT_W'(cell_size_q);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc_check) begin
					state_d = empty_patch ? ST_DONE : ST_RUN;
				end
			end
			ST_RUN: begin
				if (valid_s6 && last_s6) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = state_q != ST_IDLE;
		start_seq = acc_check && !empty_patch;
		load_out  = state_q == ST_DONE && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			free_q      <= 1'b0;
			valid_s6    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s6 <= lookup.valid;
			if (acc_check) begin
				free_q <= 1'b1;
			end else if (valid_s6 && !sample_ok) begin
				// any blocked or off-map sample fails the pose
				free_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		last_s6    <= lookup.last;
		outside_s6 <= lookup.outside;
		if (load_out) begin
			pose_free_q <= free_q;
		end
	end

	fgcc_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start_seq),
		.n_long      (nl_c),
		.n_wide      (nw_c),
		.cell_size   (cell_size_q),
		.half_length (half_length_q),
		.half_width  (half_width_q),
		.smp         (smp)
	);

	fgcc_xform u_xform (
		.clk           (clk),
		.arst_n        (arst_n),
		.smp           (smp),
		.pos_x         (x_q),
		.pos_y         (y_q),
		.cos_yaw       (c_q),
		.sin_yaw       (s_q),
		.extent        (extent_q),
		.inv_cell_size (inv_cell_size_q),
		.side          (side_c),
		.lookup        (lookup)
	);

	fgcc_ram #(
		.WIDTH (LEVEL_W),
		.DEPTH (MAP_CELLS)
	) u_cost_map (
		.clk     (clk),
		.wr_en   (acc_write),
		.wr_addr (ADDR_W'(cell_index)),
		.wr_data (cell_value),
		.rd_addr (lookup.addr),
		.rd_data (rd_data)
	);

	assign out_valid = out_valid_q;
	assign pose_free = pose_free_q;

	`FGCC_ASSERT(a_retire_in_run, valid_s6 |-> state_q == ST_RUN, "lookup retired outside a walk")
	`FGCC_ASSERT(a_start_runs, start_seq |=> state_q == ST_RUN, "walk start did not enter run")
	`FGCC_ASSERT(a_done_quiet, state_q == ST_DONE |-> !smp.valid && !lookup.valid, "sample in flight at done")
	`FGCC_NEVER(a_restart_busy, start_seq && smp.valid, "walk restarted while walker busy")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for footprint_grid_collision_check: map writes and pose checks.
`timescale 1ns / 1ps
module testbench;
	import fgcc_pkg::*;

	localparam int                HALF_PERIOD    = 4;
	localparam int                MAX_WAIT       = 17;
	localparam int                SETTLE_CYCLES  = 6;
	localparam int                TAIL_CYCLES    = 40;
	localparam int                WATCHDOG_LIMIT = 5000;
	localparam int                REPORT_LIMIT   = 10;
	localparam int                RANDOM_PHASES  = 8;
	localparam int                PHASE_ITEMS    = 80;
	localparam logic [WORD_W-1:0] ONE_M          = 32'h0001_0000;

	// Mirror of the cost map and registers; predicts the pose_free verdicts.
	class footprint_verdicts;
		bit [LEVEL_W-1:0]  cost_cells [MAP_CELLS];
		bit [WORD_W-1:0]   cell_size, inv_cell, half_len, half_wid;
		bit [MSIDE_W-1:0]  side_reg;
		bit [LEVEL_W-1:0]  free_lvl;
		bit [PCOUNT_W-1:0] n_long, n_wide;
		bit                expected_free [$];
		int                bad_verdicts;

		function new();
			cell_size    = 32'h0001_0000;
			inv_cell     = 32'h0001_0000;
			half_len     = 32'h0002_0000;
			half_wid     = 32'h0001_0000;
			side_reg     = 9'd256;
			free_lvl     = 8'd250;
			n_long       = 6'd4;
			n_wide       = 6'd2;
			bad_verdicts = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
			case (idx)
			REG_CELL_SIZE:     cell_size = data;
			REG_INV_CELL_SIZE: inv_cell  = data;
			REG_HALF_LENGTH:   half_len  = data;
			REG_HALF_WIDTH:    half_wid  = data;
			REG_MAP_SIDE:      side_reg  = data[MSIDE_W-1:0];
			REG_FREE_LEVEL:    free_lvl  = data[LEVEL_W-1:0];
			REG_PATCH_LONG:    n_long    = data[PCOUNT_W-1:0];
			REG_PATCH_WIDE:    n_wide    = data[PCOUNT_W-1:0];
			default: ;
			endcase
		endfunction

		// floor(p * inv / 2^32), p non-negative Q16.16
		function longint cell_of(longint p);
			logic [79:0] prod;
			prod = p;
			prod = prod * inv_cell;
			return longint'(prod >> (2 * CELL_FRAC));
		endfunction

		function bit pose_is_free(longint x, longint y, longint c, longint s);
			longint side, nl, nw, cs, hl, hw, extent;
			longint i, j, ox, oy, px, py, cx, cy;
			bit     free;
			free = 1'b1;
			side = side_reg;
			if (side == 0) side = 1;
			if (side > MAP_SIDE_MAX) side = MAP_SIDE_MAX;
			nl = n_long;
			nw = n_wide;
			if (nl > PATCH_MAX) nl = PATCH_MAX;
			if (nw > PATCH_MAX) nw = PATCH_MAX;
			cs = cell_size;
			hl = half_len;
			hw = half_wid;
			extent = side * cs;
			// stop the walk at the first failing sample
			for (i = 0; i < nl && free; i++) begin
				ox = i * cs - hl;
				for (j = 0; j < nw && free; j++) begin
					oy = j * cs - hw;
					px = ((ox * c - oy * s) >>> ROT_FRAC) + x;
					py = ((ox * s + oy * c) >>> ROT_FRAC) + y;
					if (px < 0 || px >= extent || py < 0 || py >= extent) begin
						free = 1'b0;
					end else begin
						cx = cell_of(px);
						cy = cell_of(py);
						if (cx > side - 1) cx = side - 1;
						if (cy > side - 1) cy = side - 1;
						if (cost_cells[cy * side + cx] < free_lvl) free = 1'b0;
					end
				end
			end
			return free;
		endfunction

		function void note_request(logic act, logic [CELL_IN_W-1:0] idx,
				logic [LEVEL_W-1:0] val, longint x, longint y, longint c, longint s);
			if (act == ACT_WRITE)
				cost_cells[idx] = val;
			else
				expected_free.push_back(pose_is_free(x, y, c, s));
		endfunction

		function void check_result(logic got);
			bit want;
			if (expected_free.size() == 0) begin
				if (bad_verdicts < REPORT_LIMIT)
					$display("%0t: pose_free=%0b with no check pending", $realtime, got);
				bad_verdicts++;
			end else begin
				want = expected_free.pop_front();
				if (got !== want) begin
					if (bad_verdicts < REPORT_LIMIT)
						$display("%0t: pose_free expected %0b, got %0b", $realtime, want, got);
					bad_verdicts++;
				end
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [REG_IDX_W-1:0]     cfg_index;
	logic [WORD_W-1:0]        cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic                     action;
	logic [CELL_IN_W-1:0]     cell_index;
	logic [LEVEL_W-1:0]       cell_value;
	logic signed [WORD_W-1:0] pos_x;
	logic signed [WORD_W-1:0] pos_y;
	logic signed [TRIG_W-1:0] cos_yaw;
	logic signed [TRIG_W-1:0] sin_yaw;
	logic                     out_valid;
	logic                     out_stall;
	logic                     pose_free;

	footprint_verdicts verdicts = new();
	bit                calm = 1'b0;
	int                idle_cycles = 0;

	footprint_grid_collision_check u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.cell_index (cell_index),
		.cell_value (cell_value),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.cos_yaw    (cos_yaw),
		.sin_yaw    (sin_yaw),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pose_free  (pose_free)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	function automatic int draw_wait();
		if (calm) return 0;
		return $urandom_range(0, MAX_WAIT);
	endfunction

	// Monitor both channels and the register port; feed the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				verdicts.write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				verdicts.note_request(action, cell_index, cell_value,
					pos_x, pos_y, cos_yaw, sin_yaw);
			if (out_valid && !out_stall)
				verdicts.check_result(pose_free);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// Result side: hold stall for a drawn number of cycles before each result.
	initial begin
		int pause;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			pause = draw_wait();
			if (pause > 0) begin
				out_stall <= 1'b1;
				repeat (pause) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			@(negedge clk);
		end
	end

	task automatic send_request(logic act, logic [CELL_IN_W-1:0] idx,
			logic [LEVEL_W-1:0] val, logic [WORD_W-1:0] x, logic [WORD_W-1:0] y,
			logic [TRIG_W-1:0] c, logic [TRIG_W-1:0] s);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		action     <= act;
		cell_index <= idx;
		cell_value <= val;
		pos_x      <= x;
		pos_y      <= y;
		cos_yaw    <= c;
		sin_yaw    <= s;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic write_cell(logic [CELL_IN_W-1:0] idx, logic [LEVEL_W-1:0] val);
		send_request(ACT_WRITE, idx, val, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic check_pose(logic [WORD_W-1:0] x, logic [WORD_W-1:0] y,
			logic [TRIG_W-1:0] c, logic [TRIG_W-1:0] s);
		send_request(ACT_CHECK, $urandom, $urandom, x, y, c, s);
	endtask

	// Hold off requests until every verdict is in, then let a write finish.
	task automatic drain();
		in_valid <= 1'b0;
		while (verdicts.expected_free.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(logic [REG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
	endtask

	task automatic configure(logic [WORD_W-1:0] cs, logic [WORD_W-1:0] inv,
			logic [WORD_W-1:0] hl, logic [WORD_W-1:0] hw, logic [WORD_W-1:0] sd,
			logic [WORD_W-1:0] fl, logic [WORD_W-1:0] pl, logic [WORD_W-1:0] pw);
		drain();
		set_reg(REG_CELL_SIZE, cs);
		set_reg(REG_INV_CELL_SIZE, inv);
		set_reg(REG_HALF_LENGTH, hl);
		set_reg(REG_HALF_WIDTH, hw);
		set_reg(REG_MAP_SIDE, sd);
		set_reg(REG_FREE_LEVEL, fl);
		set_reg(REG_PATCH_LONG, pl);
		set_reg(REG_PATCH_WIDE, pw);
		cfg_we <= 1'b0;
	endtask

	// Realistic heading and a position on the map, or raw noise.
	task automatic random_check(bit noise, longint span);
		real               a;
		logic [TRIG_W-1:0] c, s;
		logic [WORD_W-1:0] x, y;
		if (noise || span < 2) begin
			x = $urandom;
			y = $urandom;
			c = $urandom;
			s = $urandom;
		end else begin
			a = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
			c = $rtoi(32767.0 * $cos(a));
			s = $rtoi(32767.0 * $sin(a));
			x = $urandom_range(0, span - 1);
			y = $urandom_range(0, span - 1);
		end
		check_pose(x, y, c, s);
	endtask

	task automatic random_phase(bit wild, int count);
		logic [WORD_W-1:0] cs, inv, hl, hw, sd, fl, pl, pw;
		longint            side, span;
		int                shift, r, n;
		if (wild) begin
			cs  = $urandom;
			inv = $urandom;
			hl  = $urandom;
			hw  = $urandom;
			sd  = $urandom;
			fl  = $urandom;
			pl  = ($urandom & ~32'h3F) | $urandom_range(0, 6);
			pw  = ($urandom & ~32'h3F) | $urandom_range(0, 6);
		end else begin
			shift = $urandom_range(0, 3);
			cs    = 32'h0000_4000 << shift;
			inv   = 32'h0004_0000 >> shift;
			sd    = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(2, 256);
			fl    = $urandom_range(120, 252);
			pl    = $urandom_range(1, 8);
			pw    = $urandom_range(1, 6);
			// center the footprint on the pose
			hl    = ((pl - 1) * cs) >> 1;
			hw    = ((pw - 1) * cs) >> 1;
		end
		configure(cs, inv, hl, hw, sd, fl, pl, pw);
		side = sd[MSIDE_W-1:0];
		if (side == 0) side = 1;
		if (side > MAP_SIDE_MAX) side = MAP_SIDE_MAX;
		span = side * longint'(cs);
		if (span > 32'h7FFF_FFFF) span = 32'h7FFF_FFFF;
		calm = ($urandom_range(0, 3) == 0);
		for (n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r == 0)
				drain();
			if (r < 25)
				write_cell($urandom,
					($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(200, 255));
			else
				random_check(r >= 88, span);
		end
		calm = 1'b0;
	endtask

	initial begin
		int k;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_CELL_SIZE;
		cfg_data   = '0;
		in_valid   = 1'b0;
		action     = ACT_WRITE;
		cell_index = '0;
		cell_value = '0;
		pos_x      = '0;
		pos_y      = '0;
		cos_yaw    = '0;
		sin_yaw    = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill the whole map back to back so no check reads an unwritten cell
		calm = 1'b1;
		for (k = 0; k < MAP_CELLS; k++)
			write_cell(k[CELL_IN_W-1:0],
				($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(200, 255));
		calm = 1'b0;

		// reset registers: centered pose, then poses at the origin and far off the map
		check_pose(32'h0080_0000, 32'h0080_0000, 16'h7FFF, 16'h0000);
		check_pose(32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h7FFF);
		check_pose(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h8000);
		check_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h7FFF);
		write_cell(16'h0000, 8'hFF);
		write_cell(16'hFFFF, 8'h00);
		check_pose(32'h00FF_8000, 32'h00FF_8000, 16'h8000, 16'h0000);

		// map side zero acts as a single cell
		configure(ONE_M, ONE_M, 0, 0, 0, 0, 1, 1);
		check_pose(32'h0000_8000, 32'h0000_8000, 16'h7FFF, 16'h0000);
		check_pose(32'h0001_8000, 32'h0000_8000, 16'h7FFF, 16'h0000);

		// oversize side and patch saturate; zero free level walks every sample
		configure(ONE_M, ONE_M, 0, 0, 511, 0, 63, 63);
		check_pose(32'h0064_0000, 32'h0064_0000, 16'h7FFF, 16'h0000);

		// empty patch along either axis
		configure(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 256, 128, 0, 5);
		check_pose($urandom, $urandom, $urandom, $urandom);
		configure(32'hFFFF_FFFF, 1, 0, 0, 1, 255, 5, 0);
		check_pose($urandom, $urandom, $urandom, $urandom);

		// reciprocal too large: indexes clamp to the last row and column
		configure(ONE_M, 32'hFFFF_FFFF, 32'h8000, 32'h8000, 16, 200, 2, 2);
		write_cell(16'h00FF, 8'hFF);
		check_pose(32'h0008_0000, 32'h0008_0000, 16'h7FFF, 16'h0000);

		// huge cells: top of the signed range still lands on the map
		configure(32'hFFFF_FFFF, 1, 0, 0, 256, 0, 2, 2);
		check_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h0000);
		check_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 16'h7FFF);

		for (k = 0; k < RANDOM_PHASES; k++)
			random_phase(k == 2 || k == 5, PHASE_ITEMS);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (verdicts.bad_verdicts == 0 && verdicts.expected_free.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hdl
hdl/fgcc_pkg.sv
hdl/fgcc_ram.sv
hdl/fgcc_seq.sv
hdl/fgcc_xform.sv
hdl/footprint_grid_collision_check.sv
tb/testbench.sv
